// ===== src/modexp_pkg.sv =====
package modexp_pkg;

   // Width of every word on the ports; fixed by the interface.
   localparam int unsigned FIELD_W = 32;

   // Default width of the internal arithmetic.
   localparam int unsigned MODEXP_WIDTH = 32;

   // Sequencer codes.
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_REDUCE = 3'd1;
   localparam logic [2:0] ST_CHECK  = 3'd2;
   localparam logic [2:0] ST_MUL    = 3'd3;
   localparam logic [2:0] ST_SQR    = 3'd4;
   localparam logic [2:0] ST_FINISH = 3'd5;

endpackage

// ===== src/modular_exponentiation.sv =====
// Sequence: the base is reduced first, then each pass over an exponent bit takes a check and a
// bit-serial pass (a multiply if the bit is set, a square if set bits remain), and a last check
// and a handover to the output register follow. The block takes one word per exponentiation,
// and takes the next word only after the result has been handed to the output register.
// Reset (synchronous, active high) empties the sequencer and the result register and sets the
// modulus to 1.
module modular_exponentiation
   import modexp_pkg::*;
#(
   parameter int unsigned WIDTH = MODEXP_WIDTH
) (
   input  logic               clock,
   input  logic               reset,
   // configuration: the modulus
   input  logic               csr_wr_en,
   input  logic [FIELD_W-1:0] csr_wr_data,
   // request words
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [FIELD_W-1:0] req_base,
   input  logic [FIELD_W-1:0] req_exponent,
   // response words
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [FIELD_W-1:0] rsp_power
);

   localparam int unsigned CNT_W = $clog2(WIDTH);

   // Control state.
   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [WIDTH-1:0] modulus_ff, modulus_in;

   // Datapath registers.
   logic [WIDTH-1:0]   sq_ff, sq_in;        // current square of the base
   logic [WIDTH-1:0]   acc_ff, acc_in;      // running result
   logic [WIDTH-1:0]   exp_ff, exp_in;      // exponent bits still to scan
   logic [WIDTH-1:0]   part_ff, part_in;    // partial product of the running pass
   logic [WIDTH-1:0]   mplr_ff, mplr_in;    // multiplier, scanned from the top bit down
   logic [WIDTH-1:0]   mcand_ff, mcand_in;  // multiplicand
   logic [FIELD_W-1:0] rsp_power_ff, rsp_power_in;

   // Shared modular step unit.
   logic [WIDTH-1:0] addend;
   logic [WIDTH+1:0] step_sum;
   logic [WIDTH+1:0] mod_ext;
   logic [WIDTH+1:0] mod2_ext;
   logic [WIDTH-1:0] step_out;

   logic req_take;
   logic rsp_take;
   logic pass_last;

   // Every pass is the same interleaved loop: part = (2 * part + bit * mcand) mod modulus,
   // one multiplier bit per cycle from the top. Reducing the base is the same loop with
   // the base as multiplier and 1 as multiplicand, which feeds the base in one bit at a time.
   // As part and mcand never exceed the modulus, the sum stays below three times the
   // modulus, so one subtraction of the modulus or of twice the modulus finishes the step.
   // A modulus of zero makes both subtractions vanish and the truncation to WIDTH bits
   // gives the product modulo 2^WIDTH.
   assign addend   = mplr_ff[WIDTH-1] ? mcand_ff : '0;
   assign step_sum = {1'b0, part_ff, 1'b0} + {2'b00, addend};
   assign mod_ext  = {2'b00, modulus_ff};
   assign mod2_ext = {1'b0, modulus_ff, 1'b0};

   always_comb begin
      priority if (step_sum >= mod2_ext) begin
         step_out = WIDTH'(step_sum - mod2_ext);
      end else if (step_sum >= mod_ext) begin
         step_out = WIDTH'(step_sum - mod_ext);
      end else begin
         step_out = WIDTH'(step_sum);
      end
   end

   // The block takes a new word only with the sequencer idle; a finished result may still
   // wait in the output register meanwhile.
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign pass_last = (cnt_ff == '0);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      modulus_in   = modulus_ff;
      sq_in        = sq_ff;
      acc_in       = acc_ff;
      exp_in       = exp_ff;
      part_in      = part_ff;
      mplr_in      = mplr_ff;
      mcand_in     = mcand_ff;
      rsp_power_in = rsp_power_ff;

      if (csr_wr_en) begin
         modulus_in = WIDTH'(csr_wr_data);
      end

      if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               // Start reducing the base modulo the modulus.
               acc_in   = WIDTH'(1);
               exp_in   = WIDTH'(req_exponent);
               part_in  = '0;
               mplr_in  = WIDTH'(req_base);
               mcand_in = WIDTH'(1);
               cnt_in   = CNT_W'(WIDTH - 1);
               state_in = ST_REDUCE;
            end
         end

         ST_REDUCE, ST_MUL, ST_SQR: begin
            part_in = step_out;
            mplr_in = mplr_ff << 1;
            cnt_in  = cnt_ff - 1'b1;
            if (pass_last) begin
               if (state_ff == ST_MUL) begin
                  acc_in = step_out;
               end else begin
                  sq_in = step_out;
               end
               state_in = ST_CHECK;
            end
         end

         ST_CHECK: begin
            part_in = '0;
            cnt_in  = CNT_W'(WIDTH - 1);
            priority if (exp_ff == '0) begin
               state_in = ST_FINISH;
            end else if (exp_ff[0]) begin
               // Fold the current square into the result, then clear the bit so that the
               // next check moves on to squaring, or finishes if no set bits remain.
               mplr_in   = sq_ff;
               mcand_in  = acc_ff;
               exp_in[0] = 1'b0;
               state_in  = ST_MUL;
            end else if (exp_ff[WIDTH-1:1] == '0) begin
               // No set bits left, so the final square is never needed.
               exp_in   = '0;
               state_in = ST_FINISH;
            end else begin
               mplr_in  = sq_ff;
               mcand_in = sq_ff;
               exp_in   = exp_ff >> 1;
               state_in = ST_SQR;
            end
         end

         ST_FINISH: begin
            // Wait until the output register is free or being emptied in this cycle.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_power_in = FIELD_W'(acc_ff);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         modulus_ff   <= WIDTH'(1);
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         modulus_ff   <= modulus_in;
      end
   end

   always_ff @(posedge clock) begin
      sq_ff        <= sq_in;
      acc_ff       <= acc_in;
      exp_ff       <= exp_in;
      part_ff      <= part_in;
      mplr_ff      <= mplr_in;
      mcand_ff     <= mcand_in;
      rsp_power_ff <= rsp_power_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_power = rsp_power_ff;

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for the modular exponentiation block.
//
// Each request word carries a base and an exponent. The block answers with one response
// word, base to the exponent modulo the modulus held in its single configuration register.
// The bench keeps its own copy of that register and its own square-and-multiply model.
// Every accepted request pushes its predicted power onto a queue. A checker process pops
// the oldest prediction for every accepted response and compares the two.
//
// The run falls into named tests, called in turn from one initial block:
//   - requests under the modulus left by reset (1), before any register write;
//   - the extremes of the operand fields under large and tiny moduli, a prime
//     modulus where Fermat's little theorem fixes the answer, and a textbook RSA pair;
//   - modulus zero, where the block is meant to work modulo 2^32 and reduce nothing;
//   - modulus one, where every result is 0 except for a zero exponent;
//   - random phases, each under a fresh modulus drawn from one of several classes.
// The modulus is only rewritten once every predicted response has come back.
//
// Both handshakes see random gaps. Most are short, a few are long, and some stretches
// have none. A watchdog ends the run if nothing is accepted for too long.
module tb
   import modexp_pkg::*;
();

   // A request at full exponent length is the slowest. Add the longest
   // response stall and the longest request gap, then allow several times that.
   localparam int unsigned WATCHDOG_LIMIT = 20000;
   // Quiet period after the last response, so that a stray extra word is still caught.
   localparam int unsigned TAIL_CYCLES    = 2500;
   localparam int unsigned ITEMS_PER_PHASE = 35;
   localparam int unsigned RANDOM_PHASES   = 7;

   logic               clock;
   logic               reset;
   logic               csr_wr_en;
   logic [FIELD_W-1:0] csr_wr_data;
   logic               req_valid;
   logic               req_stall;
   logic [FIELD_W-1:0] req_base;
   logic [FIELD_W-1:0] req_exponent;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [FIELD_W-1:0] rsp_power;

   // The bench's own copy of the modulus register, which reset sets to 1.
   logic [FIELD_W-1:0] modulus_copy = 32'd1;
   // Predicted powers, oldest first.
   logic [FIELD_W-1:0] pending_powers[$];
   int unsigned        mismatches = 0;
   int unsigned        idle_cycles = 0;

   // Sender pacing: a burst is a run of requests with no gap between them.
   int unsigned        burst_left = 0;
   // Receiver pacing: alternating runs of stalled and free cycles.
   bit                 stalling = 1'b0;
   int unsigned        hold_left = 0;

   modular_exponentiation dut (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_base     (req_base),
      .req_exponent (req_exponent),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_power    (rsp_power)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Exact product modulo m. Both operands are below 2^32, so the 64-bit product
   // never overflows. A modulus of zero means arithmetic modulo 2^32.
   function automatic logic [63:0] mul_reduce(input logic [63:0] a, input logic [63:0] b,
                                              input logic [FIELD_W-1:0] m);
      logic [63:0] product;
      product = a * b;
      if (m == '0)
         return {32'd0, product[31:0]};
      return product % m;
   endfunction

   // Right-to-left square-and-multiply. The base is reduced first, unless the modulus
   // is zero. The running result starts at 1 and is never reduced on its own, so a
   // zero exponent gives 1 even under a modulus of one.
   function automatic logic [FIELD_W-1:0] predict_power(input logic [FIELD_W-1:0] base,
                                                        input logic [FIELD_W-1:0] exponent,
                                                        input logic [FIELD_W-1:0] m);
      logic [63:0]        square;
      logic [63:0]        result;
      logic [FIELD_W-1:0] bits;
      result = 64'd1;
      bits   = exponent;
      square = (m == '0) ? {32'd0, base} : {32'd0, base % m};
      while (bits != '0) begin
         if (bits[0])
            result = mul_reduce(result, square, m);
         bits >>= 1;
         square = mul_reduce(square, square, m);
      end
      return result[FIELD_W-1:0];
   endfunction

   // Gap before the next request. Most requests follow at once or after a short
   // gap. A few wait long enough to land in the middle of a short exponentiation,
   // and a rare one leaves the block idle for a long time.
   function automatic int unsigned draw_request_gap();
      int unsigned pick;
      if (burst_left != 0) begin
         burst_left--;
         return 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         burst_left = $urandom_range(5, 15);
         return 0;
      end
      if (pick < 50)
         return 0;
      if (pick < 85)
         return $urandom_range(1, 3);
      if (pick < 96)
         return $urandom_range(20, 300);
      return $urandom_range(300, 2500);
   endfunction

   // Sends one request word and records its prediction at the edge where it is
   // accepted. Valid stays high after acceptance, so back-to-back words never see it
   // drop. A gap lowers it first.
   task automatic send_operands(input logic [FIELD_W-1:0] base,
                                input logic [FIELD_W-1:0] exponent);
      int unsigned gap;
      gap = draw_request_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_base     <= base;
      req_exponent <= exponent;
      do
         @(posedge clock);
      while (req_stall);
      pending_powers.push_back(predict_power(base, exponent, modulus_copy));
   endtask

   // Stops sending and waits until every predicted word has come back. Each request
   // gives exactly one response, so the block is idle once the queue is empty. A final
   // wait allows for the handover of the result.
   task automatic wait_until_drained();
      req_valid <= 1'b0;
      while (pending_powers.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_modulus(input logic [FIELD_W-1:0] value);
      wait_until_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      modulus_copy = value;
   endtask

   // No write yet, so the modulus is the reset value of 1. Only the zero exponent
   // gives a nonzero result.
   task automatic test_reset_modulus();
      send_operands(32'd5, 32'd0);
      send_operands(32'd5, 32'd3);
      send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF);
   endtask

   task automatic test_operand_extremes();
      // Largest modulus: operands at both ends of their range, a base equal to the
      // modulus, which reduces to zero, and single high exponent bits.
      write_modulus(32'hFFFF_FFFF);
      send_operands(32'd0, 32'd0);
      send_operands(32'd0, 32'd1);
      send_operands(32'd1, 32'hFFFF_FFFF);
      send_operands(32'hFFFF_FFFF, 32'd1);
      send_operands(32'hFFFF_FFFE, 32'd2);
      send_operands(32'h8000_0000, 32'hFFFF_FFFF);
      send_operands(32'h1234_5678, 32'h8000_0000);
      // Largest 32-bit prime: a^(p-1) is 1 for any base not divisible by p.
      write_modulus(32'hFFFF_FFFB);
      send_operands(32'd2, 32'hFFFF_FFFA);
      send_operands(32'd3, 32'd65537);
      send_operands(32'hFFFF_FFFA, 32'hFFFF_FFFF);
      // Smallest modulus above one: the result is the parity of the base.
      write_modulus(32'd2);
      send_operands(32'd7, 32'd5);
      send_operands(32'd8, 32'd3);
      // Textbook RSA key, 61 times 53: encrypt, decrypt, and encrypt a base that
      // is above the modulus and must be reduced first.
      write_modulus(32'd3233);
      send_operands(32'd65, 32'd17);
      send_operands(32'd2790, 32'd2753);
      send_operands(32'd3298, 32'd17);
   endtask

   // A zero modulus is outside the legal range. The block then wraps products at
   // 32 bits and reduces nothing else.
   task automatic test_unreduced_modulus_zero();
      write_modulus(32'd0);
      send_operands(32'd3, 32'd40);
      send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_operands(32'd2, 32'd32);
      send_operands(32'd5, 32'd0);
   endtask

   // Modulus one: everything reduces to zero except the unreduced 1 of a zero exponent.
   task automatic test_modulus_one();
      write_modulus(32'd1);
      send_operands(32'd123, 32'd0);
      send_operands(32'd123, 32'd7);
   endtask

   // Random requests, in phases under moduli of different classes. Exponents range
   // from full length, as in RSA, through short ones and the usual public exponents,
   // so that some exponentiations finish quickly and the gaps land at every stage.
   task automatic test_random_phases();
      logic [FIELD_W-1:0] modulus;
      logic [FIELD_W-1:0] base;
      logic [FIELD_W-1:0] exponent;
      int unsigned        pick;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: begin
               modulus = $urandom() | 32'h8000_0001;
            end
            1: begin
               modulus = $urandom_range(2, 255);
            end
            2: begin
               modulus = $urandom_range(256, 65535);
            end
            3: begin
               modulus = 32'hFFFF_FFFF;
            end
            4: begin
               modulus = 32'd1 << $urandom_range(1, 31);
            end
            default: begin
               modulus = $urandom();
            end
         endcase
         write_modulus(modulus);
         for (int item = 0; item < ITEMS_PER_PHASE; item++) begin
            pick = $urandom_range(0, 9);
            case (pick)
               0: begin
                  base = '0;
               end
               1: begin
                  base = modulus - 32'd1;
               end
               2: begin
                  base = 32'hFFFF_FFFF;
               end
               default: begin
                  base = $urandom();
               end
            endcase
            pick = $urandom_range(0, 9);
            if (pick < 4)
               exponent = $urandom();
            else if (pick < 6)
               exponent = $urandom_range(0, 15);
            else if (pick == 6)
               exponent = $urandom_range(0, 1) ? 32'd65537 : 32'd3;
            else
               exponent = $urandom() >> $urandom_range(0, 31);
            send_operands(base, exponent);
         end
      end
   endtask

   // Response stall: runs of stalled and free cycles in turn. Most runs are short,
   // and a few long stalls hold a finished result back. Long free runs give stretches
   // with no back-pressure at all.
   always @(posedge clock) begin
      if (hold_left == 0) begin
         stalling = !stalling;
         if (stalling)
            hold_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300)
                                                    : $urandom_range(1, 3);
         else
            hold_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400)
                                                    : $urandom_range(1, 8);
      end
      hold_left--;
      rsp_stall <= stalling;
   end

   // Every accepted response word is checked against the oldest prediction. A word
   // with nothing predicted is a failure in its own right.
   always @(posedge clock) begin : check_power
      logic [FIELD_W-1:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_powers.size() == 0) begin
            $error("power: expected no word, actual %h", rsp_power);
            mismatches++;
         end else begin
            want = pending_powers.pop_front();
            if (rsp_power !== want) begin
               $error("power: expected %h, actual %h", want, rsp_power);
               mismatches++;
            end
         end
      end
   end

   // The watchdog counts cycles in which neither channel accepts a word.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      reset        <= 1'b1;
      csr_wr_en    <= 1'b0;
      csr_wr_data  <= '0;
      req_valid    <= 1'b0;
      req_base     <= '0;
      req_exponent <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_reset_modulus();
      test_operand_extremes();
      test_unreduced_modulus_zero();
      test_modulus_one();
      test_random_phases();

      wait_until_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_powers.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

// ===== modular_exponentiation.f =====
src/modexp_pkg.sv
src/modular_exponentiation.sv
bench/tb.sv
